// File: src/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// Both expect a clock named clk_i in scope; ASSERT_CLK also expects an active-low reset named rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// File: src/cwlp_pkg.sv
package cwlp_pkg;

  localparam int CHANNELS    = 8;
  localparam int CH_W        = 3;
  localparam int SAMPLE_BITS = 12;
  localparam int FS_W        = 16;
  localparam int W_W         = 16;
  localparam int SUM_W       = 32;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int CNT_W       = 6;

  localparam logic [FS_W-1:0] FULL_SCALE_RESET = 16'd1000;

  typedef enum logic [1:0] {
    FUNC_CAL = 2'd0,
    FUNC_ACC = 2'd1,
    FUNC_FIN = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INVERT       = 2'd0,
    REG_FULL_SCALE   = 2'd1,
    REG_WEIGHTS_LOW  = 2'd2,
    REG_WEIGHTS_HIGH = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SMUL,
    S_SDIV,
    S_WSET,
    S_WMUL,
    S_ADD,
    S_FDIV,
    S_DONE
  } state_e;

endpackage

// File: src/calibrated_weighted_line_position_core.sv
// Weighted-centroid line position for an array of eight sensor channels. A calibrate
// transaction widens the stored minimum and maximum of its channel and leaves the block
// idle. An accumulate transaction clamps the sample to the channel range, scales it to
// full_scale and adds weight times the scaled value (or full_scale minus it when invert
// is set) to a numerator and the scaled value to a denominator; the block is busy after
// it for the scaling multiply, the scaling divide, the weight set-up, the weight multiply
// and the add, or only for the last three when the channel range is empty. A finish
// transaction divides numerator by denominator and loads the result register after it,
// or loads that register directly when the denominator is zero, in which case
// the last position repeats with updated low; both sums clear in either case. The item
// time is set by one shared shift-add multiplier that consumes one multiplier bit per
// cycle and one restoring divider that produces one quotient bit per cycle. Results sit
// in an output register, so a finished position may wait on out_stall_i while the next
// transactions are already taken. Configuration writes are always ready and must only
// be issued while the block is idle.
module calibrated_weighted_line_position_core
  import cwlp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Sample channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             func_i,
  input  logic [CH_W-1:0]        channel_i,
  input  logic [SAMPLE_BITS-1:0] sample_value_i,
  // Result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SUM_W-1:0]       position_o,
  output logic                   updated_o,
  // Configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  state_e state_q, state_d;

  // Configuration registers.
  logic             invert_q;
  logic [FS_W-1:0]  full_scale_q;
  logic [CFG_W-1:0] weights_low_q;
  logic [CFG_W-1:0] weights_high_q;

  // Per-channel calibration range and running sums.
  logic [SAMPLE_BITS-1:0] range_low_q  [CHANNELS];
  logic [SAMPLE_BITS-1:0] range_high_q [CHANNELS];
  logic [SUM_W-1:0]       weighted_sum_q;
  logic [SUM_W-1:0]       plain_sum_q;
  logic [SUM_W-1:0]       last_position_q;

  // Serial datapath. acc_q is the product accumulator during a multiply and the
  // dividend/quotient shift register during a divide.
  logic [SUM_W-1:0] acc_q;
  logic [SUM_W-1:0] rem_q;
  logic [SUM_W-1:0] div_q;
  logic [SUM_W-1:0] mcand_q;
  logic [W_W-1:0]   mplier_q;
  logic [CNT_W-1:0] cnt_q;
  logic [FS_W-1:0]  v_q;
  logic [W_W-1:0]   weight_q;
  logic             upd_q;

  // Output register.
  logic             out_valid_q;
  logic [SUM_W-1:0] position_q;
  logic             updated_q;

  logic                   in_acc;
  logic                   fin_acc;
  func_e                  in_func;
  logic                   ch_ok;
  logic [SAMPLE_BITS-1:0] lo, hi, clip_hi, clip, offset, span;
  logic                   range_empty;
  logic [CFG_W-1:0]       weight_word;
  logic [W_W-1:0]         weight_sel;
  logic [SUM_W-1:0]       mul_sum;
  logic [SUM_W:0]         div_shift;
  logic [SUM_W+1:0]       div_diff;
  logic                   div_ok;
  logic [SUM_W-1:0]       rem_next;
  logic [SUM_W-1:0]       quo_next;
  logic [W_W-1:0]         term;
  logic                   out_free;
  logic                   last_step;
  logic [SUM_W-1:0]       pos_sel;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign position_o  = position_q;
  assign updated_o   = updated_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign in_func = func_e'(func_i);
  assign fin_acc = in_acc && in_func == FUNC_FIN;
  assign ch_ok   = int'(channel_i) < CHANNELS;

  // Clamp the sample into the channel range and take its offset from the minimum.
  assign lo          = range_low_q[channel_i];
  assign hi          = range_high_q[channel_i];
  assign range_empty = hi <= lo;
  assign clip_hi     = (sample_value_i < hi) ? sample_value_i : hi;
  assign clip        = (clip_hi > lo) ? clip_hi : lo;
  assign offset      = clip - lo;
  assign span        = hi - lo;

  // Channels 0 to 3 live in the low weight word, 4 to 7 in the high one.
  assign weight_word = channel_i[CH_W-1] ? weights_high_q : weights_low_q;
  assign weight_sel  = W_W'(weight_word >> {channel_i[1:0], 4'b0000});

  // One shift-add multiply step.
  assign mul_sum = acc_q + (mplier_q[0] ? mcand_q : '0);

  // One restoring divide step.
  assign div_shift = {rem_q, acc_q[SUM_W-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, div_q};
  assign div_ok    = !div_diff[SUM_W+1];
  assign rem_next  = div_ok ? div_diff[SUM_W-1:0] : div_shift[SUM_W-1:0];
  assign quo_next  = {acc_q[SUM_W-2:0], div_ok};

  assign term      = invert_q ? W_W'(full_scale_q - v_q) : W_W'(v_q);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign last_step = cnt_q == CNT_W'(1);
  assign pos_sel   = upd_q ? acc_q : last_position_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = state_q != S_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_func)
            FUNC_ACC: begin
              if (ch_ok) begin
                state_d = range_empty ? S_WSET : S_SMUL;
              end
            end
            FUNC_FIN: state_d = (plain_sum_q != '0) ? S_FDIV : S_DONE;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_SMUL: if (last_step) state_d = S_SDIV;
      S_SDIV: if (last_step) state_d = S_WSET;
      S_WSET: state_d = S_WMUL;
      S_WMUL: if (last_step) state_d = S_ADD;
      S_ADD:  state_d = S_IDLE;
      S_FDIV: if (last_step) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Serial datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_func == FUNC_ACC) begin
          acc_q    <= '0;
          rem_q    <= '0;
          mcand_q  <= SUM_W'(full_scale_q);
          mplier_q <= W_W'(offset);
          div_q    <= SUM_W'(span);
          cnt_q    <= CNT_W'(SAMPLE_BITS);
          weight_q <= weight_sel;
          v_q      <= '0;
        end else if (in_acc && in_func == FUNC_FIN) begin
          acc_q <= weighted_sum_q;
          rem_q <= '0;
          div_q <= plain_sum_q;
          cnt_q <= CNT_W'(SUM_W);
          upd_q <= plain_sum_q != '0;
        end
      end
      S_SMUL, S_WMUL: begin
        acc_q    <= mul_sum;
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        if (state_q == S_SMUL && last_step) begin
          cnt_q <= CNT_W'(SUM_W);
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
      S_SDIV, S_FDIV: begin
        acc_q <= quo_next;
        rem_q <= rem_next;
        cnt_q <= cnt_q - CNT_W'(1);
        // The scaled value never exceeds full_scale, so 16 quotient bits hold it.
        if (state_q == S_SDIV && last_step) begin
          v_q <= FS_W'(quo_next);
        end
      end
      S_WSET: begin
        acc_q    <= '0;
        mcand_q  <= SUM_W'(weight_q);
        mplier_q <= term;
        cnt_q    <= CNT_W'(W_W);
      end
      default: begin
      end
    endcase
  end

  // Configuration, calibration state, sums and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q        <= 1'b0;
      full_scale_q    <= FULL_SCALE_RESET;
      weights_low_q   <= '0;
      weights_high_q  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        range_low_q[i]  <= '1;
        range_high_q[i] <= '0;
      end
      weighted_sum_q  <= '0;
      plain_sum_q     <= '0;
      last_position_q <= '0;
      out_valid_q     <= 1'b0;
      position_q      <= '0;
      updated_q       <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_INVERT:       invert_q       <= cfg_data_i[0];
          REG_FULL_SCALE:   full_scale_q   <= cfg_data_i[FS_W-1:0];
          REG_WEIGHTS_LOW:  weights_low_q  <= cfg_data_i;
          REG_WEIGHTS_HIGH: weights_high_q <= cfg_data_i;
          default: begin
          end
        endcase
      end

      if (in_acc && in_func == FUNC_CAL && ch_ok) begin
        if (sample_value_i < lo) begin
          range_low_q[channel_i] <= sample_value_i;
        end
        if (sample_value_i > hi) begin
          range_high_q[channel_i] <= sample_value_i;
        end
      end

      if (fin_acc) begin
        weighted_sum_q <= '0;
        plain_sum_q    <= '0;
      end else if (state_q == S_ADD) begin
        weighted_sum_q <= weighted_sum_q + acc_q;
        plain_sum_q    <= plain_sum_q + SUM_W'(v_q);
      end

      // A new result may load in the same cycle the previous one is taken.
      if (state_q == S_DONE && out_free) begin
        out_valid_q     <= 1'b1;
        position_q      <= pos_sel;
        updated_q       <= upd_q;
        last_position_q <= pos_sel;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_out_from_done, $rose(out_valid_o) |-> $past(state_q == S_DONE), "result without finish")
  `ASSERT_CLK(a_fin_div_start, (fin_acc && plain_sum_q != '0) |=> state_q == S_FDIV, "no divide")
  `ASSERT_CLK(a_fin_clears, fin_acc |=> weighted_sum_q == '0 && plain_sum_q == '0, "sums kept")
  `ASSERT_CLK(a_scaled_bound, (state_q == S_WSET) |-> (v_q <= full_scale_q), "scaled too large")

endmodule

// File: test/calibrated_weighted_line_position_core_tb.sv
module calibrated_weighted_line_position_core_tb
  import cwlp_pkg::*;
();

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES = 1500;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [1:0]             func;
    logic [CH_W-1:0]        channel;
    logic [SAMPLE_BITS-1:0] sample;
  } sample_t;

  typedef struct packed {
    logic [SUM_W-1:0] position;
    logic             updated;
  } position_t;

  typedef struct packed {
    sample_t   item;
    logic      typed;
    position_t want;
  } dir_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [1:0]             func_i = FUNC_CAL;
  logic [CH_W-1:0]        channel_i = '0;
  logic [SAMPLE_BITS-1:0] sample_value_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [SUM_W-1:0]       position_o;
  logic                   updated_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = REG_INVERT;
  logic [CFG_W-1:0]       cfg_data_i = '0;

  calibrated_weighted_line_position_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .channel_i      (channel_i),
    .sample_value_i (sample_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .position_o     (position_o),
    .updated_o      (updated_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Shadow copy of the calibration, the running sums and the registers.
  logic [SAMPLE_BITS-1:0] range_lo [CHANNELS];
  logic [SAMPLE_BITS-1:0] range_hi [CHANNELS];
  logic [SUM_W-1:0]       numerator_sum;
  logic [SUM_W-1:0]       denominator_sum;
  logic [SUM_W-1:0]       last_position;
  logic                   invert_q;
  logic [FS_W-1:0]        full_scale_q;
  logic [CFG_W-1:0]       weights_lo_q;
  logic [CFG_W-1:0]       weights_hi_q;

  position_t pending_positions [$];

  int  in_idle_pct = 0;
  int  out_stall_pct = 0;
  int  frame_left = 0;
  int  error_count = 0;
  int  samples_taken = 0;
  int  positions_checked = 0;
  int  cycle_count = 0;
  bit  pressure_start = 1'b0;
  bit  hold_off = 1'b0;

  // Directed rows run with weights 0, 1000, 2000, 3000 on channels 0..3 and
  // 4000, 5000, 6000, 65535 on channels 4..7, full scale 1000, no inversion.
  dir_row_t directed_rows [24] = '{
    '{'{FUNC_FIN, 3'd0, 12'd0},       1'b1, '{32'd0, 1'b0}},
    '{'{FUNC_ACC, 3'd3, 12'd4095},    1'b0, '{32'd0, 1'b0}},
    '{'{FUNC_FIN, 3'd0, 12'd0},       1'b1, '{32'd0, 1'b0}},
    '{'{FUNC_CAL, 3'd0, 12'd0},       1'b0, '{32'd0, 1'b0}},
    '{'{FUNC_CAL, 3'd0, 12'd4095},    1'b0, '{32'd0, 1'b0}},
    '{'{FUNC_ACC, 3'd0, 12'd4095},    1'b0, '{32'd0, 1'b0}},
    '{'{FUNC_FIN, 3'd7, 12'd4095},    1'b1, '{32'd0, 1'b1}},
    '{'{FUNC_CAL, 3'd7, 12'd0},       1'b0, '{32'd0, 1'b0}},
    '{'{FUNC_CAL, 3'd7, 12'd4095},    1'b0, '{32'd0, 1'b0}},
    '{'{FUNC_ACC, 3'd7, 12'd4095},    1'b0, '{32'd0, 1'b0}},
    '{'{FUNC_FIN, 3'd0, 12'd0},       1'b1, '{32'd65535, 1'b1}},
    '{'{FUNC_ACC, 3'd7, 12'd0},       1'b0, '{32'd0, 1'b0}},
    '{'{FUNC_FIN, 3'd0, 12'd0},       1'b1, '{32'd65535, 1'b0}},
    '{'{FUNC_UNUSED, 3'd5, 12'd4095}, 1'b0, '{32'd0, 1'b0}},
    '{'{FUNC_CAL, 3'd5, 12'd2048},    1'b0, '{32'd0, 1'b0}},
    '{'{FUNC_ACC, 3'd5, 12'd4095},    1'b0, '{32'd0, 1'b0}},
    '{'{FUNC_FIN, 3'd0, 12'd0},       1'b1, '{32'd65535, 1'b0}},
    '{'{FUNC_CAL, 3'd2, 12'd100},     1'b0, '{32'd0, 1'b0}},
    '{'{FUNC_CAL, 3'd2, 12'd3000},    1'b0, '{32'd0, 1'b0}},
    '{'{FUNC_ACC, 3'd2, 12'd50},      1'b0, '{32'd0, 1'b0}},
    '{'{FUNC_ACC, 3'd2, 12'd4000},    1'b0, '{32'd0, 1'b0}},
    '{'{FUNC_ACC, 3'd0, 12'd2047},    1'b0, '{32'd0, 1'b0}},
    '{'{FUNC_ACC, 3'd1, 12'd1234},    1'b0, '{32'd0, 1'b0}},
    '{'{FUNC_FIN, 3'd0, 12'd0},       1'b0, '{32'd0, 1'b0}}
  };

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      range_lo[i] = '1;
      range_hi[i] = '0;
    end
    numerator_sum = '0;
    denominator_sum = '0;
    last_position = '0;
    invert_q = 1'b0;
    full_scale_q = FULL_SCALE_RESET;
    weights_lo_q = '0;
    weights_hi_q = '0;
  end

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= REPORT_MAX) $display("MISMATCH: %s", msg);
  endfunction

  // Calibrated reading of one sample: clamp into the channel range and map
  // that range onto 0..full_scale. An empty range reads as zero.
  function automatic logic [SUM_W-1:0] scaled_reading(logic [CH_W-1:0] ch,
                                                      logic [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    logic [SAMPLE_BITS-1:0] c;
    logic [SUM_W-1:0]       prod;
    lo = range_lo[ch];
    hi = range_hi[ch];
    if (hi <= lo) return '0;
    c = (s < hi) ? s : hi;
    c = (c > lo) ? c : lo;
    prod = SUM_W'(c - lo) * SUM_W'(full_scale_q);
    return prod / SUM_W'(hi - lo);
  endfunction

  task automatic predict_position(input sample_t it, output logic has,
                                  output position_t res);
    logic [SUM_W-1:0] v;
    logic [SUM_W-1:0] t;
    logic [W_W-1:0]   w;
    logic [63:0]      prod;
    has = 1'b0;
    res = '0;
    case (it.func)
      FUNC_CAL: begin
        if (it.sample < range_lo[it.channel]) range_lo[it.channel] = it.sample;
        if (it.sample > range_hi[it.channel]) range_hi[it.channel] = it.sample;
      end
      FUNC_ACC: begin
        v = scaled_reading(it.channel, it.sample);
        w = (it.channel < 4) ? weights_lo_q[it.channel[1:0]*W_W +: W_W]
                             : weights_hi_q[it.channel[1:0]*W_W +: W_W];
        t = invert_q ? SUM_W'(full_scale_q) - v : v;
        prod = 64'(t) * 64'(w);
        numerator_sum = numerator_sum + prod[SUM_W-1:0];
        denominator_sum = denominator_sum + v;
      end
      FUNC_FIN: begin
        if (denominator_sum != 0) begin
          last_position = numerator_sum / denominator_sum;
          res.updated = 1'b1;
        end
        res.position = last_position;
        numerator_sum = '0;
        denominator_sum = '0;
        has = 1'b1;
      end
      default: begin
      end
    endcase
  endtask

  // Offers one sample; the sender may first go idle for a random stretch.
  task automatic offer(input sample_t it, input logic typed, input position_t want);
    logic      has;
    position_t got;
    if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid_i <= 1'b1;
    func_i <= it.func;
    channel_i <= it.channel;
    sample_value_i <= it.sample;
    do @(posedge clk_i); while (in_stall_o);
    predict_position(it, has, got);
    if (has) pending_positions.push_back(typed ? want : got);
    samples_taken++;
  endtask

  task automatic put_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_INVERT:       invert_q = data[0];
      REG_FULL_SCALE:   full_scale_q = data[FS_W-1:0];
      REG_WEIGHTS_LOW:  weights_lo_q = data;
      REG_WEIGHTS_HIGH: weights_hi_q = data;
      default: begin
      end
    endcase
  endtask

  task automatic write_regs(input logic inv, input logic [FS_W-1:0] fs,
                            input logic [CFG_W-1:0] wl, input logic [CFG_W-1:0] wh);
    put_reg(REG_INVERT, CFG_W'(inv));
    put_reg(REG_FULL_SCALE, CFG_W'(fs));
    put_reg(REG_WEIGHTS_LOW, wl);
    put_reg(REG_WEIGHTS_HIGH, wh);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every position has come back, then lets an accumulate that
  // produces no result run to completion.
  task automatic settle();
    while (pending_positions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [CFG_W-1:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  // Frames of accumulates closed by a finish, with calibrates and unused codes
  // mixed in. A frame of length zero gives back-to-back finishes.
  function automatic sample_t random_item(int frame_max);
    sample_t it;
    int      r;
    it.channel = CH_W'($urandom_range(CHANNELS - 1));
    it.sample = SAMPLE_BITS'($urandom_range(4095));
    if (frame_left == 0) begin
      it.func = FUNC_FIN;
      frame_left = $urandom_range(frame_max);
      return it;
    end
    frame_left--;
    r = $urandom_range(99);
    if (r < 8) begin
      it.func = FUNC_UNUSED;
    end else if (r < 20) begin
      // Channel 6 is left uncalibrated; ranges mostly grow around mid-scale.
      it.func = FUNC_CAL;
      if (it.channel == 3'd6) it.channel = 3'd7;
      if ($urandom_range(9) != 0) it.sample = SAMPLE_BITS'($urandom_range(1024, 3072));
    end else begin
      it.func = FUNC_ACC;
      if (r >= 95) it.sample = r[0] ? '1 : '0;
    end
    return it;
  endfunction

  task automatic run_phase(input int in_pct, input int out_pct, input int frame_max,
                           input int count);
    sample_t it;
    int      sent;
    in_idle_pct = in_pct;
    out_stall_pct = out_pct;
    sent = 0;
    while (sent < count) begin
      it = random_item(frame_max);
      offer(it, 1'b0, '0);
      if (it.func != FUNC_UNUSED) sent++;
    end
    in_valid_i <= 1'b0;
    settle();
  endtask

  // Receiver stall: random per phase, forced high during the hold-off.
  always @(posedge clk_i) begin
    out_stall_i <= hold_off || (out_stall_pct != 0 && $urandom_range(99) < out_stall_pct);
  end

  // Long receiver hold-off so the output register fills and the input stalls.
  initial begin
    wait (pressure_start);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    position_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_positions.size() == 0) begin
        flag_error($sformatf("unexpected position %0d updated %0b", position_o, updated_o));
      end else begin
        want = pending_positions.pop_front();
        if (position_o !== want.position)
          flag_error($sformatf("position expected %0d got %0d", want.position, position_o));
        if (updated_o !== want.updated)
          flag_error($sformatf("updated expected %0b got %0b", want.updated, updated_o));
        positions_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_regs(1'b0, 16'd1000, {16'd3000, 16'd2000, 16'd1000, 16'd0},
               {16'hffff, 16'd6000, 16'd5000, 16'd4000});
    foreach (directed_rows[i])
      offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    in_valid_i <= 1'b0;
    settle();

    write_regs(1'b0, 16'd1000, random_word(), random_word());
    run_phase(0, 0, 8, 200);
    write_regs(1'b1, 16'hffff, '1, '1);
    run_phase(56, 0, 8, 150);
    write_regs(1'b0, 16'd1, random_word(), random_word());
    run_phase(0, 56, 8, 150);
    write_regs(1'b1, FS_W'($urandom()), random_word(), random_word());
    run_phase(15, 15, 8, 150);
    write_regs(1'b0, FS_W'($urandom_range(1, 65535)), random_word(), random_word());
    pressure_start = 1'b1;
    run_phase(0, 0, 2, 120);
    write_regs(1'b1, 16'd0, '0, '0);
    run_phase(15, 15, 8, 60);

    $display("Took %0d samples and checked %0d positions across seven register settings,",
             samples_taken, positions_checked);
    $display("with sender gaps, receiver stalls and one long output hold-off.");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
